// File: rtl/core/dsf_pkg.sv
// Shared types and constants of the decimal string formatter.
package dsf_pkg;

  localparam int unsigned DefValueBits = 64;
  localparam int unsigned FracW        = 5;
  localparam logic [FracW-1:0] MaxFraction = 5'd20;

  localparam logic [7:0] AsciiZero  = 8'h30;
  localparam logic [7:0] AsciiPoint = 8'h2e;
  localparam logic [7:0] AsciiComma = 8'h2c;
  localparam logic [7:0] AsciiMinus = 8'h2d;

  typedef struct packed {
    logic signed [63:0] value;
    logic [FracW-1:0]   fraction_digits;
  } dsf_in_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } dsf_out_t;

  typedef struct packed {
    logic             neg;
    logic [FracW-1:0] fd;
  } dsf_cls_t;

endpackage

// File: rtl/core/dsf_front.sv
// Front end: takes items, splits sign and magnitude, and queues them for the back end.
module dsf_front #(
  parameter int unsigned VALUE_BITS = dsf_pkg::DefValueBits
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  dsf_pkg::dsf_in_t      item_i,
  output logic                  q_valid_o,
  input  logic                  q_pop_i,
  output dsf_pkg::dsf_cls_t     q_cls_o,
  output logic [VALUE_BITS-1:0] q_mag_o
);
  import dsf_pkg::*;

  logic [VALUE_BITS-1:0] x;
  logic [VALUE_BITS-1:0] mag;
  dsf_cls_t              cls;

  dsf_cls_t              cls_q [2];
  logic [VALUE_BITS-1:0] mag_q [2];
  logic                  wr_ptr_q, wr_ptr_d;
  logic                  rd_ptr_q, rd_ptr_d;
  logic [1:0]            count_q, count_d;
  logic                  do_push, do_pop;

  assign x       = item_i.value[VALUE_BITS-1:0];
  assign cls.neg = x[VALUE_BITS-1];
  assign mag     = cls.neg ? (~x + 1'b1) : x;
  assign cls.fd  = (item_i.fraction_digits > MaxFraction) ? MaxFraction
                                                          : item_i.fraction_digits;

  assign full      = (count_q == 2'd2);
  assign q_valid_o = (count_q != 2'd0);
  assign q_cls_o   = cls_q[rd_ptr_q];
  assign q_mag_o   = mag_q[rd_ptr_q];
  assign do_push   = push && !full;
  assign do_pop    = q_pop_i && q_valid_o;

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      cls_q[wr_ptr_q] <= cls;
      mag_q[wr_ptr_q] <= mag;
    end
  end

endmodule

// File: rtl/core/dsf_back.sv
// Back end: shift-and-add-3 conversion to decimal digits, then serial character output.
module dsf_back #(
  parameter int unsigned VALUE_BITS = dsf_pkg::DefValueBits
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  output logic                  q_pop_o,
  input  dsf_pkg::dsf_cls_t     q_cls_i,
  input  logic [VALUE_BITS-1:0] q_mag_i,
  output logic                  empty,
  input  logic                  pop,
  output dsf_pkg::dsf_out_t     result_o
);
  import dsf_pkg::*;

  localparam int unsigned MagDigits = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int unsigned NDig      = (MagDigits > 21) ? MagDigits : 21;
  localparam int unsigned IdxW      = $clog2(NDig);
  localparam int unsigned CntW      = $clog2(VALUE_BITS);

  typedef enum logic [2:0] {
    StIdle, StConv, StSkip, StSign, StInt, StComma, StPoint, StFrac
  } state_e;

  function automatic logic [1:0] mod3(input logic [IdxW-1:0] v);
    logic [2:0] r;
    r = 3'd0;
    for (int i = IdxW - 1; i >= 0; i--) begin
      r = {r[1:0], 1'b0} + {2'b00, v[i]};
      if (r >= 3'd3) begin
        r = r - 3'd3;
      end
    end
    return r[1:0];
  endfunction

  state_e                state_q, state_d;
  logic [NDig*4-1:0]     bcd_q, bcd_d;
  logic [NDig*4-1:0]     adj;
  logic [VALUE_BITS-1:0] mag_q, mag_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [IdxW-1:0]       idx_q, idx_d;
  logic [1:0]            ph_q, ph_d;
  logic                  neg_q, neg_d;
  logic [FracW-1:0]      fd_q, fd_d;
  logic                  ovalid_q, ovalid_d;
  dsf_out_t              out_q, out_d;

  logic                  free;
  logic [3:0]            digit;
  logic [IdxW-1:0]       fd_ext;
  logic                  at_fd;

  assign free     = !ovalid_q || pop;
  assign digit    = bcd_q[idx_q*4 +: 4];
  assign fd_ext   = IdxW'(fd_q);
  assign at_fd    = (idx_q == fd_ext);
  assign empty    = !ovalid_q;
  assign result_o = out_q;
  assign q_pop_o  = (state_q == StIdle) && q_valid_i;

  always_comb begin
    for (int d = 0; d < NDig; d++) begin
      adj[d*4 +: 4] = (bcd_q[d*4 +: 4] >= 4'd5) ? bcd_q[d*4 +: 4] + 4'd3 : bcd_q[d*4 +: 4];
    end
  end

  always_comb begin
    state_d  = state_q;
    bcd_d    = bcd_q;
    mag_d    = mag_q;
    cnt_d    = cnt_q;
    idx_d    = idx_q;
    ph_d     = ph_q;
    neg_d    = neg_q;
    fd_d     = fd_q;
    ovalid_d = ovalid_q && !pop;
    out_d    = out_q;
    unique case (state_q)
      StIdle: begin
        if (q_valid_i) begin
          bcd_d   = '0;
          mag_d   = q_mag_i;
          neg_d   = q_cls_i.neg;
          fd_d    = q_cls_i.fd;
          cnt_d   = CntW'(VALUE_BITS - 1);
          state_d = StConv;
        end
      end
      StConv: begin
        bcd_d = {adj[NDig*4-2:0], mag_q[VALUE_BITS-1]};
        mag_d = {mag_q[VALUE_BITS-2:0], 1'b0};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          idx_d   = IdxW'(NDig - 1);
          state_d = StSkip;
        end
      end
      StSkip: begin
        if ((digit == 4'd0) && (idx_q > fd_ext)) begin
          idx_d = idx_q - 1'b1;
        end else begin
          ph_d    = mod3(idx_q - fd_ext);
          state_d = neg_q ? StSign : StInt;
        end
      end
      StSign: begin
        if (free) begin
          ovalid_d        = 1'b1;
          out_d.character = AsciiMinus;
          out_d.last      = 1'b0;
          state_d         = StInt;
        end
      end
      StInt: begin
        if (free) begin
          ovalid_d        = 1'b1;
          out_d.character = AsciiZero + {4'd0, digit};
          out_d.last      = at_fd && (fd_q == '0);
          idx_d           = idx_q - 1'b1;
          ph_d            = (ph_q == 2'd0) ? 2'd2 : ph_q - 2'd1;
          if (at_fd) begin
            state_d = (fd_q == '0) ? StIdle : StPoint;
          end else if (ph_q == 2'd0) begin
            state_d = StComma;
          end
        end
      end
      StComma: begin
        if (free) begin
          ovalid_d        = 1'b1;
          out_d.character = AsciiComma;
          out_d.last      = 1'b0;
          state_d         = StInt;
        end
      end
      StPoint: begin
        if (free) begin
          ovalid_d        = 1'b1;
          out_d.character = AsciiPoint;
          out_d.last      = 1'b0;
          state_d         = StFrac;
        end
      end
      StFrac: begin
        if (free) begin
          ovalid_d        = 1'b1;
          out_d.character = AsciiZero + {4'd0, digit};
          out_d.last      = (idx_q == '0);
          idx_d           = idx_q - 1'b1;
          if (idx_q == '0) begin
            state_d = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      ovalid_q <= 1'b0;
      bcd_q    <= '0;
      mag_q    <= '0;
      cnt_q    <= '0;
      idx_q    <= '0;
      ph_q     <= 2'd0;
      neg_q    <= 1'b0;
      fd_q     <= '0;
      out_q    <= '0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
      bcd_q    <= bcd_d;
      mag_q    <= mag_d;
      cnt_q    <= cnt_d;
      idx_q    <= idx_d;
      ph_q     <= ph_d;
      neg_q    <= neg_d;
      fd_q     <= fd_d;
      out_q    <= out_d;
    end
  end

endmodule

// File: rtl/core/decimal_string_formatter.sv
// Top level of the decimal string formatter: signed integer in, ASCII text out.
//
// Items enter through a queue-style port: an item is taken at a clock edge where
// push is high and full is low. It carries a signed value, of which the low
// VALUE_BITS bits count, and the number of fraction digits, saturated at twenty.
// Characters leave through a second queue-style port: while empty is low the
// oldest character is on result_o, and it is taken at an edge where pop is high.
// The last character of each number carries the last flag.
// A two-entry queue sits in front of the converter, so up to two items are
// taken while the converter is busy or the receiver stalls.
// Each item is loaded, converted by the shift-and-add-3 loop over its VALUE_BITS
// magnitude bits, and its leading zero digits are skipped; then its characters
// (1 to 26 with VALUE_BITS of 64) are sent one per cycle while the receiver keeps up.
// When the receiver stalls, the output register holds its character and the
// character output waits; the conversion and the digit skip do not wait on it.
// Reset empties the queue and the output and drops any item.
module decimal_string_formatter #(
  parameter int unsigned VALUE_BITS = dsf_pkg::DefValueBits
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  dsf_pkg::dsf_in_t  item_i,
  output logic              empty,
  input  logic              pop,
  output dsf_pkg::dsf_out_t result_o
);
  import dsf_pkg::*;

  logic                  q_valid;
  logic                  q_pop;
  dsf_cls_t              q_cls;
  logic [VALUE_BITS-1:0] q_mag;

  dsf_front #(
    .VALUE_BITS(VALUE_BITS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push     (push),
    .full     (full),
    .item_i   (item_i),
    .q_valid_o(q_valid),
    .q_pop_i  (q_pop),
    .q_cls_o  (q_cls),
    .q_mag_o  (q_mag)
  );

  dsf_back #(
    .VALUE_BITS(VALUE_BITS)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_valid_i(q_valid),
    .q_pop_o  (q_pop),
    .q_cls_i  (q_cls),
    .q_mag_i  (q_mag),
    .empty    (empty),
    .pop      (pop),
    .result_o (result_o)
  );

endmodule
